@@ design/madt_pkg.sv @@
// Package for the interrupt-controller table stream parser.
// Holds the transaction payload types, command and status codes and table offsets.
// No dependencies; every design file refers to it by scoped names.
package madt_pkg;

    // Command codes carried in the input transaction
    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_NEXT   = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    // Status codes returned in every result transaction
    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_BADLEN  = 3'd2;
    localparam logic [2:0] ST_BADSIG  = 3'd3;
    localparam logic [2:0] ST_BADSUM  = 3'd4;
    localparam logic [2:0] ST_IGNORED = 3'd5;

    // Header layout (byte offsets)
    localparam logic [31:0] OFS_LEN_LO    = 32'd4;
    localparam logic [31:0] OFS_HDR_END   = 32'd8;
    localparam logic [31:0] OFS_LEN_LAST  = 32'd7;
    localparam logic [31:0] OFS_LAPIC_LO  = 32'd36;
    localparam logic [31:0] OFS_LAPIC_END = 32'd40;
    localparam logic [31:0] OFS_ENTRIES   = 32'd44;
    localparam logic [31:0] MIN_TABLE_LEN = 32'd36;

    // Expected signature "APIC"
    localparam logic [7:0] SIG_BYTES [4] = '{8'h41, 8'h50, 8'h49, 8'h43};

    // Entry layout
    localparam logic [7:0] ET_CPU       = 8'd0;
    localparam logic [7:0] ET_IOAPIC    = 8'd1;
    localparam logic [7:0] ET_OVERRIDE  = 8'd2;
    localparam logic [7:0] ET_LAPIC_OVR = 8'd5;
    localparam logic [7:0] EPOS_TYPE    = 8'd0;
    localparam logic [7:0] EPOS_LEN     = 8'd1;
    localparam logic [7:0] EPOS_FLD_LO  = 8'd4;
    localparam logic [7:0] EPOS_FLD_HI  = 8'd7;
    localparam logic [7:0] EPOS_SRC     = 8'd4;
    localparam logic [7:0] ENTRY_MIN    = 8'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic [7:0] irq;
    } item_t;

    typedef struct packed {
        logic [2:0]  parse_status;
        logic [31:0] lapic_addr;
        logic [31:0] ioapic_addr;
        logic [7:0]  cpu_count;
        logic        table_present;
        logic        lookup_ok;
        logic [7:0]  gsi;
        logic        polarity_low;
        logic        trigger_level;
    } result_t;

    // One override store entry
    typedef struct packed {
        logic       trigger_level;
        logic       polarity_low;
        logic [7:0] gsi;
    } ovr_entry_t;

    // Requests from the parser to the override store
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_idx;
        ovr_entry_t wr_data;
        logic       clear_pending;
        logic       commit;
        logic       rd_en;
        logic [7:0] rd_idx;
    } ovr_req_t;

    // Result fields known at accept time, held while the store read completes
    typedef struct packed {
        logic [2:0]  parse_status;
        logic [31:0] lapic_addr;
        logic [31:0] ioapic_addr;
        logic [7:0]  cpu_count;
        logic        table_present;
        logic        lookup_ok;
        logic [7:0]  irq;
    } pre_result_t;

endpackage

@@ design/madt_table_stream_parser_unit.sv @@
// Top level of the interrupt-controller table stream parser.
// Usage:
//   item channel  : item_valid / item_stall / item (command, data_byte, irq).
//   result channel: result_valid / result_stall / result, one result per item.
//   Command begin starts a table with its byte, next feeds the following bytes,
//   lookup returns the committed routing of one irq.
// Timing:
//   One item is taken per cycle, back to back, while item_stall is low. The read stage
//   and the registered read of the override memory capture at the accepting edge; the
//   output register captures when the read stage advances, and result_valid follows it.
// Reset:
//   rst_n clears all parse and committed state; the override store reads as
//   default routing (gsi equal to irq, flags zero) until a table is committed.
//   Memory contents need no clearing pass.
// Stall:
//   While result_stall holds, the output register holds its transaction, the
//   read stage fills, and then item_stall rises until the result is taken.
// Depends on madt_pkg, madt_parser and madt_ovr_store.
module madt_table_stream_parser_unit #(
    parameter int MAX_TABLE_BYTES = 1048576,
    parameter int OVERRIDE_SLOTS  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  madt_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output madt_pkg::result_t result
);

    madt_pkg::ovr_req_t    req;
    madt_pkg::pre_result_t info;
    madt_pkg::ovr_entry_t  rd_data;
    logic                  rd_vld;
    logic                  accept;

    logic                  s1_valid_reg, s1_valid_next;
    madt_pkg::pre_result_t s1_info_reg;
    logic                  out_valid_reg, out_valid_next;
    madt_pkg::result_t     out_reg, out_next;
    logic                  s1_advance;

    // Handshake: the read stage moves on whenever the output register frees up
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && out_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    madt_parser #(
        .MAX_TABLE_BYTES (MAX_TABLE_BYTES),
        .OVERRIDE_SLOTS  (OVERRIDE_SLOTS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .req    (req),
        .info   (info)
    );

    madt_ovr_store #(
        .OVERRIDE_SLOTS (OVERRIDE_SLOTS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data),
        .rd_vld  (rd_vld)
    );

    // Build the result from the read stage and the store data
    always_comb
    begin
        out_next.parse_status  = s1_info_reg.parse_status;
        out_next.lapic_addr    = s1_info_reg.lapic_addr;
        out_next.ioapic_addr   = s1_info_reg.ioapic_addr;
        out_next.cpu_count     = s1_info_reg.cpu_count;
        out_next.table_present = s1_info_reg.table_present;
        out_next.lookup_ok     = s1_info_reg.lookup_ok;
        out_next.gsi           = '0;
        out_next.polarity_low  = 1'b0;
        out_next.trigger_level = 1'b0;
        if (s1_info_reg.lookup_ok)
        begin
            if (rd_vld)
            begin
                out_next.gsi           = rd_data.gsi;
                out_next.polarity_low  = rd_data.polarity_low;
                out_next.trigger_level = rd_data.trigger_level;
            end
            else
            begin
                out_next.gsi = s1_info_reg.irq;
            end
        end
    end

    // Valid flags of the read stage and the output register
    always_comb
    begin
        s1_valid_next = accept | (s1_valid_reg & !s1_advance);
        out_valid_next = s1_advance | (out_valid_reg & result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture on accept, hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= info;
        end
        if (s1_advance)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ design/madt_ovr_store.sv @@
// Override store: two banks of one synchronous memory, pending and active.
// Commit flips the bank pointer; per-entry valid bits give default routing.
// Depends on madt_pkg.
module madt_ovr_store #(
    parameter int OVERRIDE_SLOTS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  madt_pkg::ovr_req_t    req,
    output madt_pkg::ovr_entry_t  rd_data,
    output logic                  rd_vld
);

    localparam int IDX_W = (OVERRIDE_SLOTS > 1) ? $clog2(OVERRIDE_SLOTS) : 1;
    localparam int DEPTH = 2 ** (IDX_W + 1);

    madt_pkg::ovr_entry_t mem [DEPTH];
    madt_pkg::ovr_entry_t rd_data_reg;
    logic                 rd_vld_reg;
    logic                 bank_reg;
    logic                 bank_next;
    logic [DEPTH-1:0]     vld_reg;
    logic [DEPTH-1:0]     vld_next;
    logic [IDX_W:0]       wr_addr;
    logic [IDX_W:0]       rd_addr;

    // Writes go to the pending bank, lookups read the active bank
    assign wr_addr = {~bank_reg, req.wr_idx[IDX_W-1:0]};
    assign rd_addr = {bank_reg, req.rd_idx[IDX_W-1:0]};

    // Valid bits: clear the pending bank on begin, mark on write
    always_comb
    begin
        vld_next = vld_reg;
        if (req.clear_pending)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (i / (DEPTH / 2) != int'(bank_reg))
                begin
                    vld_next[i] = 1'b0;
                end
            end
        end
        if (req.wr_en)
        begin
            vld_next[wr_addr] = 1'b1;
        end
        bank_next = req.commit ? ~bank_reg : bank_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            bank_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            bank_reg <= bank_next;
        end
    end

    // Memory array with registered read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_vld  = rd_vld_reg;

endmodule

@@ design/madt_parser.sv @@
// Byte parser: header, checksum, signature and entry walk, plus committed results.
// Issues writes, clears, commits and lookups to the override store.
// Depends on madt_pkg.
module madt_parser #(
    parameter int MAX_TABLE_BYTES = 1048576,
    parameter int OVERRIDE_SLOTS  = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  madt_pkg::item_t          item,
    output madt_pkg::ovr_req_t       req,
    output madt_pkg::pre_result_t    info
);

    localparam int OFF_W = $clog2(MAX_TABLE_BYTES + 1);

    // Parse state
    logic [OFF_W-1:0] off_reg, off_next;
    logic [31:0]      len_reg, len_next;
    logic [7:0]       sum_reg, sum_next;
    logic             sig_reg, sig_next;
    logic             stop_reg, stop_next;
    logic [7:0]       epos_reg, epos_next;
    logic [7:0]       etype_reg, etype_next;
    logic [7:0]       elen_reg, elen_next;
    logic [31:0]      fc_reg, fc_next;
    logic [7:0]       src_reg, src_next;
    logic [31:0]      plapic_reg, plapic_next;
    logic [31:0]      pioapic_reg, pioapic_next;
    logic             pseen_reg, pseen_next;
    logic [7:0]       pcpus_reg, pcpus_next;
    // Committed results
    logic [31:0]      alapic_reg, alapic_next;
    logic [31:0]      aioapic_reg, aioapic_next;
    logic [7:0]       acpus_reg, acpus_next;
    logic             accepted_reg, accepted_next;

    // Starting point of this byte (cleared on begin)
    logic [OFF_W-1:0] base_off;
    logic [31:0]      base_len;
    logic [7:0]       base_sum;
    logic             base_sig;
    logic             base_stop;
    logic [7:0]       base_epos;
    logic [7:0]       base_etype;
    logic [7:0]       base_elen;
    logic [31:0]      base_fc;
    logic [7:0]       base_src;
    logic [31:0]      base_plapic;
    logic [31:0]      base_pioapic;
    logic             base_pseen;
    logic [7:0]       base_pcpus;

    logic             is_begin;
    logic             take;
    logic [31:0]      o32;
    logic [OFF_W-1:0] off_inc;
    logic             bad_len;
    logic [8:0]       pos_inc;
    logic             commit;
    logic [2:0]       status;
    logic             look_ok;
    logic [7:0]       b;

    assign b        = item.data_byte;
    assign is_begin = (item.command == madt_pkg::CMD_BEGIN);

    // Pick the starting state for this byte
    always_comb
    begin
        if (is_begin)
        begin
            base_off     = '0;
            base_len     = '0;
            base_sum     = '0;
            base_sig     = 1'b1;
            base_stop    = 1'b0;
            base_epos    = '0;
            base_etype   = '0;
            base_elen    = '0;
            base_fc      = '0;
            base_src     = '0;
            base_plapic  = '0;
            base_pioapic = '0;
            base_pseen   = 1'b0;
            base_pcpus   = '0;
        end
        else
        begin
            base_off     = off_reg;
            base_len     = len_reg;
            base_sum     = sum_reg;
            base_sig     = sig_reg;
            base_stop    = stop_reg;
            base_epos    = epos_reg;
            base_etype   = etype_reg;
            base_elen    = elen_reg;
            base_fc      = fc_reg;
            base_src     = src_reg;
            base_plapic  = plapic_reg;
            base_pioapic = pioapic_reg;
            base_pseen   = pseen_reg;
            base_pcpus   = pcpus_reg;
        end
    end

    // A continuation byte counts only while a table is open
    assign take = is_begin
        || (item.command == madt_pkg::CMD_NEXT && off_reg != '0
            && (32'(off_reg) < madt_pkg::OFS_HDR_END || 32'(off_reg) < len_reg));

    assign o32     = 32'(base_off);
    assign off_inc = base_off + 1'b1;
    assign pos_inc = {1'b0, base_epos} + 9'd1;
    assign look_ok = (item.command == madt_pkg::CMD_LOOKUP)
        && (32'(item.irq) < 32'(OVERRIDE_SLOTS)) && accepted_reg;

    // Take one table byte
    always_comb
    begin
        off_next      = off_reg;
        len_next      = len_reg;
        sum_next      = sum_reg;
        sig_next      = sig_reg;
        stop_next     = stop_reg;
        epos_next     = epos_reg;
        etype_next    = etype_reg;
        elen_next     = elen_reg;
        fc_next       = fc_reg;
        src_next      = src_reg;
        plapic_next   = plapic_reg;
        pioapic_next  = pioapic_reg;
        pseen_next    = pseen_reg;
        pcpus_next    = pcpus_reg;
        bad_len       = 1'b0;
        commit        = 1'b0;
        req           = '0;
        status        = (item.command == madt_pkg::CMD_LOOKUP) ? madt_pkg::ST_BUSY
                                                               : madt_pkg::ST_IGNORED;

        if (accept && take)
        begin
            off_next     = base_off;
            len_next     = base_len;
            sum_next     = base_sum + b;
            sig_next     = base_sig;
            stop_next    = base_stop;
            epos_next    = base_epos;
            etype_next   = base_etype;
            elen_next    = base_elen;
            fc_next      = base_fc;
            src_next     = base_src;
            plapic_next  = base_plapic;
            pioapic_next = base_pioapic;
            pseen_next   = base_pseen;
            pcpus_next   = base_pcpus;
            status       = madt_pkg::ST_BUSY;

            if (o32 < madt_pkg::OFS_LEN_LO)
            begin
                if (b != madt_pkg::SIG_BYTES[base_off[1:0]])
                begin
                    sig_next = 1'b0;
                end
            end
            else if (o32 < madt_pkg::OFS_HDR_END)
            begin
                len_next[{base_off[1:0], 3'b000} +: 8] = base_len[{base_off[1:0], 3'b000} +: 8] | b;
                if (o32 == madt_pkg::OFS_LEN_LAST
                    && (len_next < madt_pkg::MIN_TABLE_LEN
                        || len_next > 32'(MAX_TABLE_BYTES)))
                begin
                    len_next = '0;
                    off_next = OFF_W'(madt_pkg::OFS_HDR_END);
                    bad_len  = 1'b1;
                    status   = madt_pkg::ST_BADLEN;
                end
            end
            else if (o32 >= madt_pkg::OFS_LAPIC_LO && o32 < madt_pkg::OFS_LAPIC_END)
            begin
                plapic_next[{base_off[1:0], 3'b000} +: 8] =
                    base_plapic[{base_off[1:0], 3'b000} +: 8] | b;
            end
            else if (o32 >= madt_pkg::OFS_ENTRIES && !base_stop)
            begin
                // Walk one entry byte
                if (base_epos == madt_pkg::EPOS_TYPE)
                begin
                    etype_next = b;
                    fc_next    = '0;
                end
                else if (base_epos == madt_pkg::EPOS_LEN)
                begin
                    elen_next = b;
                    if (b < madt_pkg::ENTRY_MIN)
                    begin
                        stop_next = 1'b1;
                    end
                    else if (base_etype == madt_pkg::ET_CPU && base_pcpus != 8'hFF)
                    begin
                        pcpus_next = base_pcpus + 8'd1;
                    end
                end
                else
                begin
                    if (base_epos >= madt_pkg::EPOS_FLD_LO && base_epos <= madt_pkg::EPOS_FLD_HI)
                    begin
                        fc_next[{base_epos[1:0], 3'b000} +: 8] =
                            base_fc[{base_epos[1:0], 3'b000} +: 8] | b;
                    end
                    if (base_etype == madt_pkg::ET_OVERRIDE && base_epos == madt_pkg::EPOS_SRC)
                    begin
                        src_next = b;
                    end
                    if (base_epos == madt_pkg::EPOS_FLD_HI)
                    begin
                        if (base_etype == madt_pkg::ET_IOAPIC && !base_pseen)
                        begin
                            pioapic_next = fc_next;
                            pseen_next   = 1'b1;
                        end
                        else if (base_etype == madt_pkg::ET_LAPIC_OVR)
                        begin
                            plapic_next = fc_next;
                        end
                        else if (base_etype == madt_pkg::ET_OVERRIDE
                                 && 32'(base_src) < 32'(OVERRIDE_SLOTS))
                        begin
                            req.wr_en                 = 1'b1;
                            req.wr_idx                = base_src;
                            req.wr_data.gsi           = fc_next[23:16];
                            req.wr_data.polarity_low  = b[0];
                            req.wr_data.trigger_level = b[1];
                        end
                    end
                end
                // Advance the entry position unless the walk just stopped
                if (!(base_epos == madt_pkg::EPOS_LEN && b < madt_pkg::ENTRY_MIN))
                begin
                    if (pos_inc >= 9'd2 && pos_inc >= {1'b0, elen_next})
                    begin
                        epos_next = '0;
                    end
                    else
                    begin
                        epos_next = pos_inc[7:0];
                    end
                end
            end

            // Advance the offset and judge the table on its last byte
            if (!bad_len)
            begin
                off_next = off_inc;
                if (o32 >= madt_pkg::OFS_HDR_END && 32'(off_inc) >= len_next)
                begin
                    priority if (sum_next != 8'd0)
                    begin
                        status = madt_pkg::ST_BADSUM;
                    end
                    else if (!sig_next)
                    begin
                        status = madt_pkg::ST_BADSIG;
                    end
                    else
                    begin
                        status = madt_pkg::ST_OK;
                        commit = 1'b1;
                    end
                end
            end
        end

        req.clear_pending = accept && is_begin;
        req.commit        = commit;
        req.rd_en         = accept && (item.command == madt_pkg::CMD_LOOKUP);
        req.rd_idx        = item.irq;
    end

    // Commit pending results
    always_comb
    begin
        alapic_next   = commit ? plapic_next  : alapic_reg;
        aioapic_next  = commit ? pioapic_next : aioapic_reg;
        acpus_next    = commit ? pcpus_next   : acpus_reg;
        accepted_next = commit | accepted_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg      <= '0;
            len_reg      <= '0;
            sum_reg      <= '0;
            sig_reg      <= 1'b0;
            stop_reg     <= 1'b0;
            epos_reg     <= '0;
            etype_reg    <= '0;
            elen_reg     <= '0;
            fc_reg       <= '0;
            src_reg      <= '0;
            plapic_reg   <= '0;
            pioapic_reg  <= '0;
            pseen_reg    <= 1'b0;
            pcpus_reg    <= '0;
            alapic_reg   <= '0;
            aioapic_reg  <= '0;
            acpus_reg    <= '0;
            accepted_reg <= 1'b0;
        end
        else
        begin
            off_reg      <= off_next;
            len_reg      <= len_next;
            sum_reg      <= sum_next;
            sig_reg      <= sig_next;
            stop_reg     <= stop_next;
            epos_reg     <= epos_next;
            etype_reg    <= etype_next;
            elen_reg     <= elen_next;
            fc_reg       <= fc_next;
            src_reg      <= src_next;
            plapic_reg   <= plapic_next;
            pioapic_reg  <= pioapic_next;
            pseen_reg    <= pseen_next;
            pcpus_reg    <= pcpus_next;
            alapic_reg   <= alapic_next;
            aioapic_reg  <= aioapic_next;
            acpus_reg    <= acpus_next;
            accepted_reg <= accepted_next;
        end
    end

    // Result fields of this transaction, as they stand after it
    always_comb
    begin
        info.parse_status  = status;
        info.lapic_addr    = alapic_next;
        info.ioapic_addr   = aioapic_next;
        info.cpu_count     = acpus_next;
        info.table_present = accepted_next;
        info.lookup_ok     = look_ok;
        info.irq           = item.irq;
    end

endmodule
